// File: rtl/gsfs_pkg.sv
// shared widths, codes and reset values of the grid slot free stack
`default_nettype none

package gsfs_pkg;

  // field and port widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned FREE_W     = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;

  // stack depth default
  localparam int unsigned MAX_CELLS = 512;

  // register reset values
  localparam int unsigned RESET_ROWS = 10;
  localparam int unsigned RESET_COLS = 20;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

endpackage

`default_nettype wire

// File: rtl/grid_slot_free_stack_core.sv
// top level: lifo free list of grid cells with serial coordinate decode
// clear, no-op, release and any error are answered from the execute state, without the divider
// reserve passes through the execute, read and divide states and answers when the serial divider is done
// one request at a time; the next is taken at the edge that ends the result strobe
// reset: asynchronous, grid 10 by 20, all cells free with position k holding cell k+1
// the stack memory needs no clearing pass: a low-water mark stands for untouched entries
`default_nettype none

module grid_slot_free_stack_core #(
  parameter int unsigned MaxCells = gsfs_pkg::MAX_CELLS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [gsfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gsfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [gsfs_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [gsfs_pkg::ROW_W-1:0]      row_in_i,
  input  wire logic [gsfs_pkg::COL_W-1:0]      col_in_i,
  // result
  output logic                                 done_o,
  output logic      [gsfs_pkg::STATUS_W-1:0]   status_o,
  output logic      [gsfs_pkg::ROW_W-1:0]      row_out_o,
  output logic      [gsfs_pkg::COL_W-1:0]      col_out_o,
  output logic      [gsfs_pkg::FREE_W-1:0]     free_count_o
);

  import gsfs_pkg::*;

  localparam int unsigned CntW      = $clog2(MaxCells + 1);
  localparam int unsigned AddrW     = (MaxCells > 1) ? $clog2(MaxCells) : 1;
  localparam int unsigned ResetProd = RESET_ROWS * RESET_COLS;
  localparam logic [CntW-1:0] ResetCap =
    CntW'((ResetProd > MaxCells) ? MaxCells : ResetProd);
  localparam int unsigned ProdW = ROW_W + COL_W;
  localparam int unsigned CellW = ProdW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DIV
  } state_e;

  state_e state_q;

  // configuration registers
  logic [ROW_W-1:0] num_rows_q;
  logic [COL_W-1:0] num_cols_q;

  // stack control state
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] lwm_q;

  // registered request
  logic [FUNC_W-1:0] func_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;

  // registered result
  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [ROW_W-1:0]    row_out_q;
  logic [COL_W-1:0]    col_out_q;
  logic [CntW-1:0]     free_q;

  logic             accept;
  logic [ROW_W-1:0] eff_rows;
  logic [COL_W-1:0] eff_cols;
  logic [ProdW-1:0] grid_prod;
  logic [CntW-1:0]  cap;
  logic [ProdW-1:0] rel_prod;
  logic [CellW-1:0] rel_cell;
  logic             rel_outside;
  logic [CntW-1:0]  count_m1;
  logic [CntW-1:0]  pop_cell;
  logic [CntW-1:0]  new_lwm;

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [CntW-1:0]  ram_rdata;

  logic             div_start;
  logic             div_done;
  logic [CntW-1:0]  div_quot;
  logic [COL_W-1:0] div_rem;

  assign accept = start_i && (state_q == ST_IDLE);

  // effective grid size and capacity
  always_comb begin
    eff_rows  = (num_rows_q == '0) ? ROW_W'(1) : num_rows_q;
    eff_cols  = (num_cols_q == '0) ? COL_W'(1) : num_cols_q;
    grid_prod = ProdW'(eff_rows) * ProdW'(eff_cols);
    cap       = (32'(grid_prod) > 32'(MaxCells)) ? CntW'(MaxCells) : CntW'(grid_prod);
  end

  // release cell number and coordinate check
  always_comb begin
    rel_prod    = ProdW'(row_q - 1'b1) * ProdW'(eff_cols);
    rel_cell    = CellW'(rel_prod) + CellW'(col_q);
    rel_outside = (row_q == '0) || (row_q > eff_rows) ||
                  (col_q == '0) || (col_q > eff_cols) ||
                  (32'(rel_cell) > 32'(MaxCells));
  end

  // pop source: untouched entries below the low-water mark hold their position plus one
  always_comb begin
    count_m1 = count_q - 1'b1;
    pop_cell = (count_q == lwm_q) ? count_q : ram_rdata;
    new_lwm  = (count_m1 < lwm_q) ? count_m1 : lwm_q;
  end

  // stack memory access
  always_comb begin
    ram_we   = (state_q == ST_EXEC) && (func_q == FUNC_RELEASE) &&
               !rel_outside && (count_q < cap);
    ram_addr = ram_we ? count_q[AddrW-1:0] : count_m1[AddrW-1:0];
  end

  assign div_start = (state_q == ST_READ);

  gsfs_ram #(
    .Width (CntW),
    .Depth (MaxCells),
    .AddrW (AddrW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (CntW'(rel_cell)),
    .rdata_o (ram_rdata)
  );

  gsfs_div #(
    .DvdW (CntW),
    .DvsW (COL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pop_cell - 1'b1),
    .divisor_i  (eff_cols),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= ROW_W'(RESET_ROWS);
      num_cols_q <= COL_W'(RESET_COLS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_ROWS: num_rows_q <= cfg_data_i[ROW_W-1:0];
        REG_NUM_COLS: num_cols_q <= cfg_data_i[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      row_q  <= row_in_i;
      col_q  <= col_in_i;
    end
  end

  // sequencer, stack counters and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= ResetCap;
      lwm_q     <= ResetCap;
      done_q    <= 1'b0;
      status_q  <= STAT_OK;
      row_out_q <= '0;
      col_out_q <= '0;
      free_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          row_out_q <= '0;
          col_out_q <= '0;
          status_q  <= STAT_OK;
          free_q    <= count_q;
          case (func_q)
            FUNC_RESERVE: begin
              if (count_q == '0) begin
                status_q <= STAT_EMPTY;
                done_q   <= 1'b1;
                state_q  <= ST_IDLE;
              end else begin
                state_q <= ST_READ;
              end
            end
            FUNC_RELEASE: begin
              if (rel_outside) begin
                status_q <= STAT_OUTSIDE;
              end else if (count_q >= cap) begin
                status_q <= STAT_FULL;
              end else begin
                count_q <= count_q + 1'b1;
                free_q  <= count_q + 1'b1;
              end
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
            FUNC_CLEAR: begin
              count_q <= cap;
              lwm_q   <= cap;
              free_q  <= cap;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
            default: begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_READ: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            row_out_q <= ROW_W'(div_quot + 1'b1);
            col_out_q <= div_rem + 1'b1;
            status_q  <= STAT_OK;
            count_q   <= count_m1;
            lwm_q     <= new_lwm;
            free_q    <= count_m1;
            done_q    <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign row_out_o    = row_out_q;
  assign col_out_o    = col_out_q;
  assign free_count_o = FREE_W'(free_q);

`ifndef ASSERT_OFF
  // the low-water mark never rises above the free count
  a_lwm_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lwm_q <= count_q) else $error("low-water mark above free count");

  // the free count never exceeds the stack depth
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxCells)) else $error("free count beyond stack depth");

  // error results carry no coordinates
  a_err_no_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STAT_OK)) |-> (row_out_o == '0) && (col_out_o == '0))
    else $error("coordinates on an error result");

  // the divider finishes only while the sequencer waits for it
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV)) else $error("divider done outside wait state");
`endif

endmodule

`default_nettype wire

// File: rtl/gsfs_ram.sv
// generic single port ram with registered read
`default_nettype none

module gsfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

// File: rtl/gsfs_div.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module gsfs_div #(
  parameter int unsigned DvdW = 10,
  parameter int unsigned DvsW = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic      [DvdW-1:0] quot_o,
  output logic      [DvsW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            take;

  // one trial subtraction step
  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    diff  = trial - {1'b0, dvs_q};
    take  = (trial >= {1'b0, dvs_q});
    rem_d = take ? diff[DvsW-1:0] : trial[DvsW-1:0];
    dvd_d = {dvd_q[DvdW-2:0], take};
  end

  // iteration counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(DvdW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: verif/gsfs_alloc_checker.sv
// request/result checker with a free-list predictor for the grid slot free stack
`timescale 1ns / 1ps

module gsfs_alloc_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gsfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gsfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            start_i,
  input  wire logic                            busy_i,
  input  wire logic [gsfs_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [gsfs_pkg::ROW_W-1:0]      row_in_i,
  input  wire logic [gsfs_pkg::COL_W-1:0]      col_in_i,
  input  wire logic                            done_i,
  input  wire logic [gsfs_pkg::STATUS_W-1:0]   status_i,
  input  wire logic [gsfs_pkg::ROW_W-1:0]      row_out_i,
  input  wire logic [gsfs_pkg::COL_W-1:0]      col_out_i,
  input  wire logic [gsfs_pkg::FREE_W-1:0]     free_count_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o
);

  import gsfs_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [FREE_W-1:0]   free;
  } cell_answer_t;

  // predicted state of the block
  logic [ROW_W-1:0]   grid_rows;
  logic [COL_W-1:0]   grid_cols;
  logic [FREE_W-1:0]  free_cells [MAX_CELLS];
  int unsigned        free_depth;

  cell_answer_t       answers_due [$];
  int unsigned        mismatches = 0;

  // refill the free list in ascending cell order
  task automatic refill_free_cells(input int unsigned cap);
    for (int unsigned k = 0; k < MAX_CELLS; k++) begin
      free_cells[k] = FREE_W'(k + 1);
    end
    free_depth = cap;
  endtask

  // advance the predicted free list by one request and form its result
  task automatic settle_request(input logic [FUNC_W-1:0] fn, input logic [ROW_W-1:0] row,
                                input logic [COL_W-1:0] col, output cell_answer_t ans);
    int unsigned eff_rows;
    int unsigned eff_cols;
    int unsigned cap;
    int unsigned cell_num;
    int unsigned offset;
    eff_rows = (grid_rows == '0) ? 1 : grid_rows;
    eff_cols = (grid_cols == '0) ? 1 : grid_cols;
    cap      = eff_rows * eff_cols;
    if (cap > MAX_CELLS) cap = MAX_CELLS;
    ans = '0;
    ans.status = STAT_OK;
    case (fn)
      FUNC_RESERVE: begin
        if (free_depth == 0) begin
          ans.status = STAT_EMPTY;
        end else begin
          cell_num = free_cells[free_depth-1];
          offset   = cell_num - 1;
          ans.row  = ROW_W'(offset / eff_cols + 1);
          ans.col  = COL_W'(offset % eff_cols + 1);
          free_depth--;
        end
      end
      FUNC_RELEASE: begin
        cell_num = (32'(row) - 1) * eff_cols + 32'(col);
        if (row == '0 || row > eff_rows || col == '0 || col > eff_cols ||
            cell_num > MAX_CELLS) begin
          ans.status = STAT_OUTSIDE;
        end else if (free_depth >= cap) begin
          ans.status = STAT_FULL;
        end else begin
          free_cells[free_depth] = FREE_W'(cell_num);
          free_depth++;
        end
      end
      FUNC_CLEAR: begin
        refill_free_cells(cap);
      end
      default: ;
    endcase
    ans.free = FREE_W'(free_depth);
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input logic [FREE_W-1:0] act_val);
    if ({1'b0, act_val} !== 11'(exp_val)) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // watch both channels at every rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    cell_answer_t ans;
    if (!rst_ni) begin
      grid_rows = ROW_W'(RESET_ROWS);
      grid_cols = COL_W'(RESET_COLS);
      refill_free_cells(RESET_ROWS * RESET_COLS);
      answers_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // register writes
      if (cfg_we_i === 1'b1) begin
        if (cfg_idx_i == REG_NUM_ROWS) begin
          grid_rows = cfg_data_i[ROW_W-1:0];
        end else begin
          grid_cols = cfg_data_i[COL_W-1:0];
        end
      end
      // accepted request
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        settle_request(func_i, row_in_i, col_in_i, ans);
        answers_due = {answers_due, ans};
      end
      // result strobe
      if (done_i === 1'b1) begin
        if (answers_due.size() == 0) begin
          $error("result with no request outstanding: status %0d", status_i);
          mismatches++;
        end else begin
          ans = answers_due.pop_front();
          check_field("status", ans.status, FREE_W'(status_i));
          check_field("row_out", ans.row, FREE_W'(row_out_i));
          check_field("col_out", ans.col, FREE_W'(col_out_i));
          check_field("free_count", ans.free, free_count_i);
        end
      end
      pending_o    <= answers_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: verif/tb_grid_slot_free_stack_core.sv
// testbench top: request stimulus, grid settings and verdict for the free stack core
`timescale 1ns / 1ps

module tb_grid_slot_free_stack_core;
  import gsfs_pkg::*;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  start_i    = 1'b0;
  logic [FUNC_W-1:0]     func_i     = FUNC_NOP;
  logic [ROW_W-1:0]      row_in_i   = '0;
  logic [COL_W-1:0]      col_in_i   = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [ROW_W-1:0]      row_out_o;
  logic [COL_W-1:0]      col_out_o;
  logic [FREE_W-1:0]     free_count_o;

  int unsigned           fail_count;
  int unsigned           pending;

  // stimulus view of the grid, used only to aim releases inside it
  int unsigned           stim_rows = RESET_ROWS;
  int unsigned           stim_cols = RESET_COLS;
  bit                    gaps_on   = 1'b1;

  always #5 clk_i = ~clk_i;

  grid_slot_free_stack_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .row_in_i     (row_in_i),
    .col_in_i     (col_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .row_out_o    (row_out_o),
    .col_out_o    (col_out_o),
    .free_count_o (free_count_o)
  );

  gsfs_alloc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .func_i       (func_i),
    .row_in_i     (row_in_i),
    .col_in_i     (col_in_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .row_out_i    (row_out_o),
    .col_out_i    (col_out_o),
    .free_count_i (free_count_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // present one request and hold it until the core takes it
  task automatic issue(input logic [FUNC_W-1:0] fn, input logic [ROW_W-1:0] row,
                       input logic [COL_W-1:0] col);
    int unsigned gap;
    gap = 0;
    while (gaps_on && $urandom_range(99) < 17) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    func_i   <= fn;
    row_in_i <= row;
    col_in_i <= col;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // stop issuing and let every outstanding result come back
  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write both grid registers while the core is idle
  task automatic set_grid(input logic [CFG_DATA_W-1:0] rows_word,
                          input logic [CFG_DATA_W-1:0] cols_word);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_NUM_ROWS;
    cfg_data_i <= rows_word;
    @(posedge clk_i);
    cfg_idx_i  <= REG_NUM_COLS;
    cfg_data_i <= cols_word;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    stim_rows = (rows_word[ROW_W-1:0] == '0) ? 1 : rows_word[ROW_W-1:0];
    stim_cols = (cols_word[COL_W-1:0] == '0) ? 1 : cols_word[COL_W-1:0];
  endtask

  // one random request: mostly reserves and in-grid releases, some noise
  task automatic random_request(input int unsigned reserve_pct);
    int unsigned pick;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pick = $urandom_range(99);
    row  = ROW_W'($urandom_range(31));
    col  = COL_W'($urandom_range(63));
    if (pick < reserve_pct) begin
      issue(FUNC_RESERVE, row, col);
    end else if (pick < 90) begin
      issue(FUNC_RELEASE, ROW_W'($urandom_range(1, stim_rows)),
            COL_W'($urandom_range(1, stim_cols)));
    end else if (pick < 95) begin
      issue(FUNC_RELEASE, row, col);
    end else if (pick < 98) begin
      issue(FUNC_NOP, row, col);
    end else begin
      issue(FUNC_CLEAR, row, col);
    end
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] rows_word;
    logic [CFG_DATA_W-1:0] cols_word;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset grid of 10 by 20, top of stack, full and outside cases
    issue(FUNC_RESERVE, 5'd0, 6'd0);
    issue(FUNC_RELEASE, 5'd10, 6'd20);
    issue(FUNC_RELEASE, 5'd1, 6'd1);
    issue(FUNC_RELEASE, 5'd0, 6'd1);
    issue(FUNC_RELEASE, 5'd11, 6'd20);
    issue(FUNC_RELEASE, 5'd10, 6'd21);
    issue(FUNC_RELEASE, 5'd1, 6'd0);
    issue(FUNC_RELEASE, 5'd31, 6'd63);
    issue(FUNC_NOP, 5'd31, 6'd63);
    issue(FUNC_CLEAR, 5'd31, 6'd63);
    issue(FUNC_RESERVE, 5'd31, 6'd63);

    // single cell grid: leftover stack decoded with one column, then empty
    set_grid(6'd1, 6'd1);
    issue(FUNC_RESERVE, 5'd0, 6'd0);
    issue(FUNC_CLEAR, 5'd0, 6'd0);
    issue(FUNC_RESERVE, 5'd0, 6'd0);
    issue(FUNC_RESERVE, 5'd0, 6'd0);
    issue(FUNC_RELEASE, 5'd1, 6'd1);
    issue(FUNC_RELEASE, 5'd1, 6'd1);

    // zero registers count as one
    set_grid(6'd0, 6'd0);
    issue(FUNC_RELEASE, 5'd1, 6'd1);
    issue(FUNC_RELEASE, 5'd2, 6'd1);

    // oversized grid saturates at the stack depth
    set_grid(6'd31, 6'd63);
    issue(FUNC_CLEAR, 5'd0, 6'd0);
    issue(FUNC_RELEASE, 5'd9, 6'd1);
    issue(FUNC_RELEASE, 5'd10, 6'd1);
    issue(FUNC_RESERVE, 5'd0, 6'd0);

    // column count drops under a full stack: row wraps at its width
    set_grid(6'd16, 6'd1);
    issue(FUNC_RESERVE, 5'd0, 6'd0);
    issue(FUNC_RELEASE, 5'd16, 6'd1);

    // random phases over several grids, alternating drain and fill bias
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin rows_word = 6'd1;  cols_word = 6'd1;  end
        1: begin rows_word = 6'd0;  cols_word = 6'd0;  end
        2: begin rows_word = 6'd16; cols_word = 6'd32; end
        3: begin rows_word = 6'd31; cols_word = 6'd63; end
        default: begin
          rows_word = {1'($urandom_range(1)), 5'($urandom_range(1, 5))};
          cols_word = 6'($urandom_range(1, 9));
        end
      endcase
      set_grid(rows_word, cols_word);
      if (ph == 3) issue(FUNC_CLEAR, 5'd0, 6'd0);
      gaps_on = (ph != 5);
      for (int n = 0; n < 108; n++) begin
        random_request((ph % 2 == 0) ? 65 : 30);
      end
    end
    gaps_on = 1'b1;

    // wait for the last results and for any stray strobes
    drain();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
